// ===== rtl/core/http_date_parser_top_defines.svh =====
// assertion macros shared by the date parser rtl
`ifndef HTTP_DATE_PARSER_TOP_DEFINES_SVH
`define HTTP_DATE_PARSER_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define HDP_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("http date parser: invariant violated");

// consequence that must hold in the cycle after the antecedent
`define HDP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("http date parser: next-cycle check failed");

// consequence that must hold in the same cycle as the antecedent
`define HDP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("http date parser: same-cycle check failed");

`endif

// ===== rtl/core/hdp_pkg.sv =====
// types and constants shared by the date parser modules
`timescale 1ns / 1ps

package hdp_pkg;

	localparam logic [4:0] STR_LEN = 5'd29;

	// running parse state of one date string
	typedef struct packed {
		logic [4:0]  char_position;
		logic        overlength;
		logic        format_ok;
		logic [6:0]  dayname_candidates;
		logic [11:0] monthname_candidates;
		logic [6:0]  day_accum;
		logic [13:0] year_accum;
		logic [6:0]  hour_accum;
		logic [6:0]  minute_accum;
		logic [6:0]  second_accum;
	} state_t;

	localparam state_t STATE_RESET = '{
		char_position:        5'd0,
		overlength:           1'b0,
		format_ok:            1'b1,
		dayname_candidates:   7'h7F,
		monthname_candidates: 12'hFFF,
		day_accum:            7'd0,
		year_accum:           14'd0,
		hour_accum:           7'd0,
		minute_accum:         7'd0,
		second_accum:         7'd0
	};

	// one parsed date
	typedef struct packed {
		logic        date_valid;
		logic [2:0]  weekday;
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [13:0] year_value;
		logic [4:0]  hour_value;
		logic [5:0]  minute_value;
		logic [5:0]  second_value;
	} result_t;

endpackage

// ===== rtl/core/hdp_byte_eval.sv =====
// per-byte next-state and result logic of the date parser
`timescale 1ns / 1ps

module hdp_byte_eval (
	input  hdp_pkg::state_t  st,
	input  logic [7:0]       text_byte,
	output hdp_pkg::state_t  st_next,
	output hdp_pkg::result_t res
);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	function automatic logic [23:0] weekday_abbr(input logic [2:0] i);
		logic [23:0] r;
		unique case (i)
			3'd0: r = "Mon";
			3'd1: r = "Tue";
			3'd2: r = "Wed";
			3'd3: r = "Thu";
			3'd4: r = "Fri";
			3'd5: r = "Sat";
			3'd6: r = "Sun";
			default: r = 24'd0;
		endcase
		return r;
	endfunction

	function automatic logic [23:0] month_abbr(input logic [3:0] i);
		logic [23:0] r;
		unique case (i)
			4'd0: r = "Jan";
			4'd1: r = "Feb";
			4'd2: r = "Mar";
			4'd3: r = "Apr";
			4'd4: r = "May";
			4'd5: r = "Jun";
			4'd6: r = "Jul";
			4'd7: r = "Aug";
			4'd8: r = "Sep";
			4'd9: r = "Oct";
			4'd10: r = "Nov";
			4'd11: r = "Dec";
			default: r = 24'd0;
		endcase
		return r;
	endfunction

	// literal separators; only reached at non-digit, non-name positions
	function automatic logic [7:0] fixed_char(input logic [4:0] p);
		logic [7:0] r;
		unique case (p)
			5'd3:  r = ",";
			5'd4, 5'd7, 5'd11, 5'd16, 5'd25: r = " ";
			5'd19, 5'd22: r = ":";
			5'd26: r = "G";
			5'd27: r = "M";
			5'd28: r = "T";
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// pick one character of a three-letter name
	function automatic logic [7:0] name_col(input logic [23:0] n, input logic [1:0] col);
		logic [7:0] r;
		unique case (col)
			2'd0: r = n[23:16];
			2'd1: r = n[15:8];
			default: r = n[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [6:0] acc7(input logic [6:0] acc, input logic [3:0] d);
		logic [10:0] t;
		t = 11'(acc) * 11'd10 + 11'(d);
		return t[6:0];
	endfunction

	function automatic logic [13:0] acc14(input logic [13:0] acc, input logic [3:0] d);
		logic [17:0] t;
		t = 18'(acc) * 18'd10 + 18'(d);
		return t[13:0];
	endfunction

	logic [4:0] p;
	logic       is_digit;
	logic [3:0] digit;
	logic [1:0] day_col;
	logic [1:0] mon_col;
	logic       ok;
	logic [2:0] day_idx;
	logic [3:0] mon_idx;

	assign p        = st.char_position;
	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign digit    = 4'(text_byte - CH_ZERO);
	assign day_col  = p[1:0];
	assign mon_col  = 2'(p - 5'd8);

	always_comb begin
		st_next = st;
		if (p >= hdp_pkg::STR_LEN) begin
			st_next.overlength = 1'b1;
		end else begin
			priority if (p <= 5'd2) begin
				for (int i = 0; i < 7; i++) begin
					if (name_col(weekday_abbr(3'(i)), day_col) != text_byte)
						st_next.dayname_candidates[i] = 1'b0;
				end
			end else if (p >= 5'd8 && p <= 5'd10) begin
				for (int i = 0; i < 12; i++) begin
					if (name_col(month_abbr(4'(i)), mon_col) != text_byte)
						st_next.monthname_candidates[i] = 1'b0;
				end
			end else if (p == 5'd5 || p == 5'd6) begin
				if (is_digit) st_next.day_accum = acc7(st.day_accum, digit);
				else st_next.format_ok = 1'b0;
			end else if (p >= 5'd12 && p <= 5'd15) begin
				if (is_digit) st_next.year_accum = acc14(st.year_accum, digit);
				else st_next.format_ok = 1'b0;
			end else if (p == 5'd17 || p == 5'd18) begin
				if (is_digit) st_next.hour_accum = acc7(st.hour_accum, digit);
				else st_next.format_ok = 1'b0;
			end else if (p == 5'd20 || p == 5'd21) begin
				if (is_digit) st_next.minute_accum = acc7(st.minute_accum, digit);
				else st_next.format_ok = 1'b0;
			end else if (p == 5'd23 || p == 5'd24) begin
				if (is_digit) st_next.second_accum = acc7(st.second_accum, digit);
				else st_next.format_ok = 1'b0;
			end else begin
				if (fixed_char(p) != text_byte) st_next.format_ok = 1'b0;
			end
			st_next.char_position = p + 5'd1;
		end
	end

	// lowest surviving candidate wins
	always_comb begin
		day_idx = 3'd0;
		for (int i = 6; i >= 0; i--) begin
			if (st_next.dayname_candidates[i]) day_idx = 3'(i);
		end
		mon_idx = 4'd0;
		for (int i = 11; i >= 0; i--) begin
			if (st_next.monthname_candidates[i]) mon_idx = 4'(i);
		end
	end

	assign ok = st_next.format_ok && !st_next.overlength
		&& (st_next.char_position == hdp_pkg::STR_LEN)
		&& (st_next.dayname_candidates != 7'd0)
		&& (st_next.monthname_candidates != 12'd0)
		&& (st_next.day_accum >= 7'd1) && (st_next.day_accum <= 7'd31)
		&& (st_next.year_accum <= 14'd9999)
		&& (st_next.hour_accum <= 7'd23)
		&& (st_next.minute_accum <= 7'd59)
		&& (st_next.second_accum <= 7'd60);

	always_comb begin
		res = '0;
		if (ok) begin
			res.date_valid   = 1'b1;
			res.weekday      = day_idx;
			res.day_of_month = st_next.day_accum[4:0];
			res.month_number = mon_idx + 4'd1;
			res.year_value   = st_next.year_accum;
			res.hour_value   = st_next.hour_accum[4:0];
			res.minute_value = st_next.minute_accum[5:0];
			res.second_value = st_next.second_accum[5:0];
		end
	end

endmodule

// ===== rtl/core/http_date_parser_top.sv =====
// top level of the streaming rfc 1123 http date parser
`timescale 1ns / 1ps
`include "http_date_parser_top_defines.svh"

// Parses "Ddd, DD Mon YYYY HH:MM:SS GMT" fed one ASCII byte per request,
// with end_of_string set on the final byte. One byte is accepted every
// cycle unless a final byte waits for the output slot; the parse state
// update (name candidate masks, separator check, multiply-by-ten field
// accumulators) sets that rate. Each accepted byte is held in an input
// register before it updates the state; a string's result enters the output
// register as its final byte leaves the input register and waits there
// until taken. Non-final bytes never wait on the output side; a final byte
// waits in the input register only while an earlier result is untaken. A
// result with date_valid 0 carries zeros in all other fields. Names are
// case sensitive; neither the weekday against the date nor the day against
// the month is checked. State returns to reset after every result.
module http_date_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        date_valid,
	output logic [2:0]  weekday,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_number,
	output logic [13:0] year_value,
	output logic [4:0]  hour_value,
	output logic [5:0]  minute_value,
	output logic [5:0]  second_value
);

	// input register stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// parse state and result register
	hdp_pkg::state_t  st_q;
	hdp_pkg::state_t  st_next;
	hdp_pkg::result_t res_next;
	hdp_pkg::result_t res_q;
	logic             out_valid_q;

	logic             out_free;
	logic             s1_fire;
	logic             in_fire;

	// output slot is free if empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	// a non-final byte only touches the state; a final one needs the output slot
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= text_byte;
			last_s1 <= end_of_string;
		end
	end

	hdp_byte_eval u_eval (
		.st        (st_q),
		.text_byte (byte_s1),
		.st_next   (st_next),
		.res       (res_next)
	);

	// parse state, cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hdp_pkg::STATE_RESET;
		end else if (s1_fire) begin
			st_q <= last_s1 ? hdp_pkg::STATE_RESET : st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			res_q <= res_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign date_valid   = res_q.date_valid;
	assign weekday      = res_q.weekday;
	assign day_of_month = res_q.day_of_month;
	assign month_number = res_q.month_number;
	assign year_value   = res_q.year_value;
	assign hour_value   = res_q.hour_value;
	assign minute_value = res_q.minute_value;
	assign second_value = res_q.second_value;

	// position never runs past the string length
	`HDP_ASSERT_ALWAYS(a_pos_bound, st_q.char_position <= hdp_pkg::STR_LEN)
	// overlength is only flagged once the position has saturated
	`HDP_ASSERT_SAME(a_over_sat, st_q.overlength, st_q.char_position == hdp_pkg::STR_LEN)
	// a final byte leaves the parse state at reset and a result pending
	`HDP_ASSERT_NEXT(a_final_clears, s1_fire && last_s1,
		st_q == hdp_pkg::STATE_RESET && out_valid_q)
	// a valid date always carries a real day and month
	`HDP_ASSERT_SAME(a_valid_fields, out_valid_q && res_q.date_valid,
		res_q.day_of_month != 5'd0 && res_q.month_number != 4'd0
		&& res_q.month_number <= 4'd12)

endmodule
